// File: src/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared codes, defaults and controller/datapath interface types for the
// double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int FUNC_W        = 2;
    localparam int STATUS_W      = 2;

    localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [FUNC_W-1:0] OP_POP_BACK   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic load;
        logic write;
        logic read;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic is_push;
        logic full;
        logic empty;
    } t_stat;

endpackage

`default_nettype wire

// File: src/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words held in a ring buffer of DEPTH words.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word (i_func, i_item_value) is taken on a rising edge
//   with start high and busy low. i_func selects push front, push back,
//   pop front or pop back; i_item_value is ignored for pops.
//   Result channel: exactly one result per command, shown for one cycle with
//   o_valid high: o_status (ok, empty, full), o_popped_value (zero unless a
//   pop succeeded), o_entry_count and o_is_empty after the operation.
//   Sequence: the accepting edge moves to EXEC, where the single RAM port
//   with registered read makes the access; the read word comes out in RESP,
//   where the result is shown, then the sequencer goes back to idle.
//   busy is high in EXEC and RESP, so a new command is taken only once the
//   previous result has been shown.
//   A push on a full deque or a pop on an empty one changes nothing.
//   Reset (synchronous, active low) empties the deque; stored words are not
//   cleared and need no clearing pass. The receiver cannot stall: each
//   result must be taken in the cycle it is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    input  wire logic [dq_pkg::FUNC_W-1:0]         i_func,
    input  wire logic signed [dq_pkg::WORD_W-1:0]  i_item_value,
    output logic                                   busy,
    output logic                                   o_valid,
    output logic [dq_pkg::STATUS_W-1:0]            o_status,
    output logic signed [dq_pkg::WORD_W-1:0]       o_popped_value,
    output logic [$clog2(DEPTH+1)-1:0]             o_entry_count,
    output logic                                   o_is_empty
);

    dq_pkg::t_cmd  cmd;
    dq_pkg::t_stat stat;

    dq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_func         (i_func),
        .i_item_value   (i_item_value),
        .o_stat         (stat),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_entry_count  (o_entry_count),
        .o_is_empty     (o_is_empty)
    );

endmodule

`default_nettype wire

// File: src/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Single-port RAM: each cycle one address, optional write, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: accepts a command, runs the memory access, presents the word.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire dq_pkg::t_stat i_stat,
    output dq_pkg::t_cmd       o_cmd,
    output logic               busy,
    output logic               o_valid
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.write  = 1'b0;
        o_cmd.read   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.write  = i_stat.is_push && !i_stat.full;
                o_cmd.read   = !i_stat.is_push && !i_stat.empty;
                o_cmd.commit = 1'b1;
                n_state      = S_RESP;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_RESP);

    a_exec_then_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_valid)
        else $error("result not presented after execute");

    a_load_then_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.commit)
        else $error("accepted command not executed");

    a_no_rw_together: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.write && o_cmd.read))
        else $error("write and read issued together");

endmodule

`default_nettype wire

// File: src/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath
// Front ring pointer, fill count, address generation and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_datapath #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire dq_pkg::t_cmd                      i_cmd,
    input  wire logic [dq_pkg::FUNC_W-1:0]         i_func,
    input  wire logic signed [dq_pkg::WORD_W-1:0]  i_item_value,
    output dq_pkg::t_stat                          o_stat,
    output logic [dq_pkg::STATUS_W-1:0]            o_status,
    output logic signed [dq_pkg::WORD_W-1:0]       o_popped_value,
    output logic [$clog2(DEPTH+1)-1:0]             o_entry_count,
    output logic                                   o_is_empty
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [dq_pkg::FUNC_W-1:0]        r_func;
    logic signed [dq_pkg::WORD_W-1:0] r_value;
    logic [IW-1:0]                    r_front;
    logic [CW-1:0]                    r_count;
    logic [dq_pkg::STATUS_W-1:0]      r_status;
    logic                             r_pop_ok;

    logic [IW-1:0]               front_dec;
    logic [IW-1:0]               front_inc;
    logic [SW-1:0]               tail_raw;
    logic [SW-1:0]               tail_wrap;
    logic [IW-1:0]               addr;
    logic [dq_pkg::WORD_W-1:0]   rdata;

    assign o_stat.is_push = (r_func == dq_pkg::OP_PUSH_FRONT) ||
                            (r_func == dq_pkg::OP_PUSH_BACK);
    assign o_stat.full    = (r_count == CW'(DEPTH));
    assign o_stat.empty   = (r_count == '0);

    // sum stays below 2*DEPTH, so one conditional subtract wraps it
    always_comb begin
        front_dec = (r_front == '0) ? IW'(DEPTH - 1) : r_front - 1'b1;
        front_inc = (r_front == IW'(DEPTH - 1)) ? '0 : r_front + 1'b1;
        tail_raw  = SW'(r_front) + SW'(r_count);
        if (r_func == dq_pkg::OP_POP_BACK) begin
            tail_raw = tail_raw - 1'b1;
        end
        tail_wrap = (tail_raw >= SW'(DEPTH)) ? tail_raw - SW'(DEPTH) : tail_raw;
        unique case (r_func)
            dq_pkg::OP_PUSH_FRONT: addr = front_dec;
            dq_pkg::OP_POP_FRONT:  addr = r_front;
            default:               addr = tail_wrap[IW-1:0];
        endcase
    end

    dq_ram #(
        .WIDTH (dq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_addr  (addr),
        .i_wdata (r_value),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_value <= i_item_value;
        end
        if (i_cmd.commit) begin
            r_pop_ok <= i_cmd.read;
            if (i_cmd.write || i_cmd.read) begin
                r_status <= dq_pkg::ST_OK;
            end else if (o_stat.is_push) begin
                r_status <= dq_pkg::ST_FULL;
            end else begin
                r_status <= dq_pkg::ST_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.write) begin
                r_count <= r_count + 1'b1;
                if (r_func == dq_pkg::OP_PUSH_FRONT) begin
                    r_front <= front_dec;
                end
            end else if (i_cmd.read) begin
                r_count <= r_count - 1'b1;
                if (r_func == dq_pkg::OP_POP_FRONT) begin
                    r_front <= front_inc;
                end
            end
        end
    end

    assign o_status       = r_status;
    assign o_popped_value = r_pop_ok ? $signed(rdata) : '0;
    assign o_entry_count  = r_count;
    assign o_is_empty     = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_write_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |=> r_count == CW'($past(r_count) + 1'b1))
        else $error("count not incremented on push");

    a_read_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.read |=> r_count == CW'($past(r_count) - 1'b1))
        else $error("count not decremented on pop");

endmodule

`default_nettype wire
